// ===== hw/rtl/rfns_pkg.sv =====
// Shared types and constants of the four-neighbour RGB sharpening filter.
package rfns_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int OUTQ_DEPTH    = 8;

    localparam int ROW_W    = 16;
    localparam int COL_W    = 12;
    localparam int CFG_W_W  = 13;
    localparam int CFG_H_W  = 16;
    localparam int STR_W    = 12;
    localparam int CFG_D_W  = 16;
    localparam int CFG_IX_W = 2;

    localparam logic [CFG_W_W-1:0] WIDTH_RST    = CFG_W_W'(640);
    localparam logic [CFG_H_W-1:0] HEIGHT_RST   = CFG_H_W'(480);
    localparam logic [STR_W-1:0]   STRENGTH_RST = STR_W'(256);

    typedef enum logic [CFG_IX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_STRENGTH     = 2'd2,
        CFG_UNUSED       = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0]       red_out;
        logic [7:0]       green_out;
        logic [7:0]       blue_out;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic             last_of_run;
    } t_pix_out;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    // position and result flags of one pixel, worked out at accept time
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             has_up;
        logic             has_self;
        logic             inner;
    } t_ctl;

    // neighborhood of the pixel one row above the incoming one
    typedef struct packed {
        logic vld;
        t_rgb cur;
        t_rgb lft;
        t_rgb ctr;
        t_rgb rgt;
        t_rgb up;
        t_ctl ctl;
    } t_win;

    // everything one input pixel releases (up to two results)
    typedef struct packed {
        t_rgb             up_px;
        t_rgb             self_px;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             has_up;
        logic             has_self;
    } t_item;

endpackage

// ===== hw/rtl/rfns_lbuf.sv =====
// Two line memories, row-start seed registers and the sliding window of the previous row.
module rfns_lbuf import rfns_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_acc,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]      i_col,
    input  logic                                i_sel,
    input  t_rgb                                i_cur,
    input  t_ctl                                i_ctl,
    output t_win                                o_win
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH+1);

    logic [23:0] mem_a [MAX_WIDTH];
    logic [23:0] mem_b [MAX_WIDTH];

    logic [AW-1:0] col_addr;
    logic [AW-1:0] nxt_addr;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;
    logic          we_a;
    logic          we_b;
    logic          col_is0;
    logic          col_is1;

    logic  [23:0] r_qa;
    logic  [23:0] r_qb;
    logic         r_vld;
    logic         r_sel;
    logic         r_col0;
    t_rgb         r_seed1;
    t_rgb         r_hold0;
    t_rgb         r_hold1;
    t_rgb         r_lft;
    t_rgb         r_ctr;
    t_rgb         r_cur;
    t_ctl         r_ctl;
    t_rgb         newest_q;
    t_rgb         oldest_q;
    t_rgb         right_px;

    assign col_addr = i_col[AW-1:0];
    assign nxt_addr = (i_col == CW'(MAX_WIDTH-1)) ? '0 : AW'(i_col[AW-1:0] + AW'(1));
    assign col_is0  = (i_col == '0);
    assign col_is1  = (i_col == CW'(1));

    // newest row sits in B when sel is set; the oldest row is read and overwritten in place
    assign we_a      = i_acc & i_sel;
    assign we_b      = i_acc & ~i_sel;
    assign rd_addr_a = i_sel ? col_addr : nxt_addr;
    assign rd_addr_b = i_sel ? nxt_addr : col_addr;

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_qa <= mem_a[rd_addr_a];
        end
        if (we_a) begin
            mem_a[col_addr] <= i_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_qb <= mem_b[rd_addr_b];
        end
        if (we_b) begin
            mem_b[col_addr] <= i_cur;
        end
    end

    assign newest_q = r_sel ? r_qb : r_qa;
    assign oldest_q = r_sel ? r_qa : r_qb;
    // column 0 takes its right neighbor from the seed, not the memory
    assign right_px = r_col0 ? r_seed1 : newest_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_sel   <= i_sel;
            r_col0  <= col_is0;
            r_seed1 <= r_hold1;
            r_cur   <= i_cur;
            r_ctl   <= i_ctl;
            if (col_is0) begin
                r_ctr   <= r_hold0;
                r_hold0 <= i_cur;
            end else begin
                r_lft <= r_ctr;
                r_ctr <= right_px;
            end
            if (col_is1) begin
                r_hold1 <= i_cur;
            end
        end
    end

    always_comb begin
        o_win.vld = r_vld;
        o_win.cur = r_cur;
        o_win.lft = r_lft;
        o_win.ctr = r_ctr;
        o_win.rgt = right_px;
        o_win.up  = oldest_q;
        o_win.ctl = r_ctl;
    end

endmodule

// ===== hw/rtl/rfns_core.sv =====
// Per-channel Laplacian difference, gain multiply and clamp, two register stages.
module rfns_core import rfns_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [STR_W-1:0] i_strength,
    input  t_win             i_win,
    output logic             o_push,
    output logic             o_drop,
    output t_item            o_item
);

    function automatic logic [7:0] f_clamp(input logic signed [24:0] n);
        logic [7:0] v;
        if (n < 0) begin
            v = 8'd0;
        end else if (n[23:18] != '0) begin
            v = 8'd255;
        end else begin
            v = n[17:10];
        end
        return v;
    endfunction

    logic [2:0][7:0] w_cur;
    logic [2:0][7:0] w_lft;
    logic [2:0][7:0] w_ctr;
    logic [2:0][7:0] w_rgt;
    logic [2:0][7:0] w_up;
    logic [2:0][9:0] tsum;
    logic signed [2:0][10:0] dif;
    logic signed [2:0][23:0] prod;
    logic [2:0][7:0] sharp;

    logic                    r_b_vld;
    logic signed [2:0][10:0] r_b_d;
    logic [2:0][7:0]         r_b_ctr;
    t_rgb                    r_b_cur;
    t_ctl                    r_b_ctl;

    logic                    r_c_vld;
    logic signed [2:0][24:0] r_c_n;
    logic [2:0][7:0]         r_c_ctr;
    t_rgb                    r_c_cur;
    t_ctl                    r_c_ctl;

    assign w_cur = i_win.cur;
    assign w_lft = i_win.lft;
    assign w_ctr = i_win.ctr;
    assign w_rgt = i_win.rgt;
    assign w_up  = i_win.up;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            tsum[k] = 10'(w_up[k]) + 10'(w_cur[k]) + 10'(w_lft[k]) + 10'(w_rgt[k]);
            dif[k]  = $signed({1'b0, w_ctr[k], 2'b00}) - $signed({1'b0, tsum[k]});
        end
    end

    // an element of a packed array is unsigned: take the difference as signed
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod[k] = $signed({1'b0, i_strength}) * $signed(r_b_d[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_b_vld <= i_win.vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_win.vld) begin
            r_b_d   <= dif;
            r_b_ctr <= w_ctr;
            r_b_cur <= i_win.cur;
            r_b_ctl <= i_win.ctl;
        end
        if (r_b_vld) begin
            for (int k = 0; k < 3; k++) begin
                r_c_n[k] <= $signed({7'b0, r_b_ctr[k], 10'b0}) + $signed({prod[k][23], prod[k]});
            end
            r_c_ctr <= r_b_ctr;
            r_c_cur <= r_b_cur;
            r_c_ctl <= r_b_ctl;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sharp[k] = r_c_ctl.inner ? f_clamp(r_c_n[k]) : r_c_ctr[k];
        end
    end

    assign o_push = r_c_vld & (r_c_ctl.has_up | r_c_ctl.has_self);
    assign o_drop = r_c_vld & ~r_c_ctl.has_up & ~r_c_ctl.has_self;

    always_comb begin
        o_item.up_px    = sharp;
        o_item.self_px  = r_c_cur;
        o_item.row      = r_c_ctl.row;
        o_item.col      = r_c_ctl.col;
        o_item.has_up   = r_c_ctl.has_up;
        o_item.has_self = r_c_ctl.has_self;
    end

endmodule

// ===== hw/rtl/rfns_ofifo.sv =====
// Result queue: holds finished pixels and sends one or two result beats per entry.
module rfns_ofifo import rfns_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_item    i_item,
    output logic     o_valid,
    output t_pix_out o_data,
    input  logic     i_stall,
    output logic     o_pop
);

    localparam int PW = $clog2(OUTQ_DEPTH);

    t_item         r_mem [OUTQ_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;
    logic          r_ph;

    t_item head;
    logic  emit_self;
    logic  last;
    logic  take;
    t_rgb  px;

    assign head      = r_mem[r_rp];
    assign o_valid   = (r_cnt != '0);
    assign emit_self = ~head.has_up | r_ph;
    assign last      = emit_self | ~head.has_self;
    assign take      = o_valid & ~i_stall;
    assign o_pop     = take & last;
    assign px        = emit_self ? head.self_px : head.up_px;

    always_comb begin
        o_data.red_out     = px.r;
        o_data.green_out   = px.g;
        o_data.blue_out    = px.b;
        o_data.out_row     = emit_self ? head.row : head.row - ROW_W'(1);
        o_data.out_col     = head.col;
        o_data.last_of_run = last;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_ph  <= 1'b0;
        end else begin
            if (i_push) begin
                r_wp <= PW'(r_wp + PW'(1));
            end
            if (o_pop) begin
                r_rp <= PW'(r_rp + PW'(1));
                r_ph <= 1'b0;
            end else if (take) begin
                r_ph <= 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(o_pop);
        end
    end

endmodule

// ===== hw/rtl/rgb_four_neighbour_sharpen.sv =====
// Path: each result passes the line read, difference and multiply registers, then the result queue.
// Throughput: one pixel per cycle while neither stall is raised; rows that release two results
// per pixel (last row) are held back by the single result beat per cycle on the output port.
// Each line memory takes one read and one write per cycle; up to 8 pixels may be in flight.
// Reset: counters, line select and queue clear, registers load 640 x 480, strength 0.25;
// line memory contents stay undefined until written, no clearing pass.
module rgb_four_neighbour_sharpen import rfns_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  t_pix_in             i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output t_pix_out            o_out_data,
    input  logic                i_out_stall,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_IX_W-1:0] i_cfg_index,
    input  logic [CFG_D_W-1:0]  i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH+1);
    localparam int PW = $clog2(OUTQ_DEPTH);

    logic [CFG_W_W-1:0] r_cfg_w;
    logic [CFG_H_W-1:0] r_cfg_h;
    logic [STR_W-1:0]   r_cfg_s;

    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic             r_sel;
    logic [PW:0]      r_inflight;

    logic [CW-1:0]    eff_w;
    logic [ROW_W-1:0] eff_h;
    logic             col_ov;
    logic [CW-1:0]    c0;
    logic [CW-1:0]    c1;
    logic [ROW_W:0]   row_pre;
    logic [ROW_W-1:0] r0;
    logic [ROW_W:0]   r0_inc;
    logic             sel0;
    logic             row_end;
    logic             acc;
    t_rgb             cur;
    t_ctl             ctl;
    t_win             win;
    t_item            item;
    logic             push;
    logic             drop;
    logic             pop;
    t_cfg_idx         cfg_idx;

    assign o_cfg_ready = 1'b1;
    assign cfg_idx     = t_cfg_idx'(i_cfg_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= WIDTH_RST;
            r_cfg_h <= HEIGHT_RST;
            r_cfg_s <= STRENGTH_RST;
        end else if (i_cfg_valid) begin
            case (cfg_idx)
                CFG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_data[CFG_W_W-1:0];
                CFG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_data[CFG_H_W-1:0];
                CFG_STRENGTH:     r_cfg_s <= i_cfg_data[STR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_cfg_w == '0) begin
            eff_w = CW'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = CW'(r_cfg_w);
        end
        eff_h = (r_cfg_h == '0) ? ROW_W'(1) : r_cfg_h;
    end

    assign acc        = i_in_valid & ~o_in_stall;
    assign o_in_stall = (r_inflight == (PW+1)'(OUTQ_DEPTH));
    assign cur        = i_in_data;

    // close a row left open by a width change before placing this pixel
    always_comb begin
        col_ov  = (r_col >= eff_w);
        c0      = col_ov ? '0 : r_col;
        sel0    = r_sel ^ col_ov;
        row_pre = {1'b0, r_row} + (ROW_W+1)'(col_ov);
        r0      = (row_pre >= {1'b0, eff_h}) ? '0 : row_pre[ROW_W-1:0];
        r0_inc  = {1'b0, r0} + (ROW_W+1)'(1);
        c1      = CW'(c0 + CW'(1));
        row_end = (c1 >= eff_w);

        ctl.row      = r0;
        ctl.col      = COL_W'(c0);
        ctl.has_up   = (r0 != '0);
        ctl.has_self = (r0_inc == {1'b0, eff_h});
        ctl.inner    = (r_cfg_s != '0) && (32'(eff_w) >= 3) && (eff_h >= ROW_W'(3)) &&
                       (r0 >= ROW_W'(2)) && (c0 != '0) && (c1 < eff_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_sel      <= 1'b0;
            r_inflight <= '0;
        end else begin
            if (acc) begin
                if (row_end) begin
                    r_col <= '0;
                    r_row <= (r0_inc >= {1'b0, eff_h}) ? '0 : r0_inc[ROW_W-1:0];
                    r_sel <= ~sel0;
                end else begin
                    r_col <= c1;
                    r_row <= r0;
                    r_sel <= sel0;
                end
            end
            r_inflight <= r_inflight + (PW+1)'(acc) - (PW+1)'(pop) - (PW+1)'(drop);
        end
    end

    rfns_lbuf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_lbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_col   (c0),
        .i_sel   (sel0),
        .i_cur   (cur),
        .i_ctl   (ctl),
        .o_win   (win)
    );

    rfns_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_strength (r_cfg_s),
        .i_win      (win),
        .o_push     (push),
        .o_drop     (drop),
        .o_item     (item)
    );

    rfns_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (item),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall),
        .o_pop   (pop)
    );

endmodule
